// ===== hw/rtl/wfgdd_pkg.sv =====
package wfgdd_pkg;

  // Field widths fixed by the item formats
  localparam int ID_W  = 4;
  localparam int CNT_W = 5;
  // Thread ids are four bits wide, so no more than this many entries are reachable
  localparam int MAX_IDS = 1 << ID_W;

  // Request codes
  localparam logic REQ_UPDATE = 1'b0;
  localparam logic REQ_DETECT = 1'b1;

  typedef struct packed {
    logic            req_type;
    logic [ID_W-1:0] thread_id;
    logic            present;
    logic            blocked;
    logic            waiting;
    logic            owner_valid;
    logic [ID_W-1:0] owner_id;
  } req_item_t;

  typedef struct packed {
    logic [ID_W-1:0]  member_id;
    logic             found;
    logic [CNT_W-1:0] member_count;
    logic [CNT_W-1:0] num_blocked;
    logic             last;
  } rsp_item_t;

  // One thread table entry
  typedef struct packed {
    logic            present;
    logic            blocked;
    logic            waiting;
    logic            owner_valid;
    logic [ID_W-1:0] owner;
  } entry_t;

  // Decision of one walk step
  typedef struct packed {
    logic            stop;     // path ends here
    logic            hit;      // path closed on itself
    logic [ID_W-1:0] next_id;  // successor when the walk goes on
  } walk_res_t;

endpackage

// ===== hw/rtl/wait_for_graph_deadlock_detector_core.sv =====
// Update item: writes its entry if in range, no result; next item can be taken the cycle after.
// Detect item: one pass over the table to count blocked threads, then the start scan
// plus walk steps through the one table read port, then, if a cycle was found, a pass
// over the entries to emit marked members, then the summary. No new item is taken
// until the summary is loaded; the result side can stall the emit and summary steps.
// Synchronous reset clears the thread table, the marks and the sequencer.
module wait_for_graph_deadlock_detector_core #(
  parameter int NUM_THREADS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  wfgdd_pkg::req_item_t req,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output wfgdd_pkg::rsp_item_t rsp
);

  localparam int ENTRIES = (NUM_THREADS < wfgdd_pkg::MAX_IDS) ? NUM_THREADS
                                                               : wfgdd_pkg::MAX_IDS;
  localparam int EW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_COUNT = 6'b000010,
    S_START = 6'b000100,
    S_WALK  = 6'b001000,
    S_EMIT  = 6'b010000,
    S_SUM   = 6'b100000
  } state_t;

  state_t                          state;
  logic   [CW-1:0]                 scan;
  logic   [EW-1:0]                 cur;
  logic   [ENTRIES-1:0]            visited;
  logic   [ENTRIES-1:0]            on_path;
  logic   [wfgdd_pkg::CNT_W-1:0]   blocked_cnt;
  logic   [wfgdd_pkg::CNT_W-1:0]   member_cnt;
  logic                            found;

  logic                  accept;
  logic                  wr_en;
  logic [EW-1:0]         rd_addr;
  wfgdd_pkg::entry_t     wr_data;
  wfgdd_pkg::entry_t     rd_data;
  wfgdd_pkg::walk_res_t  step;
  logic                  scan_last;
  logic                  start_ok;
  logic                  marked;
  logic                  out_free;
  logic                  load;
  wfgdd_pkg::rsp_item_t  load_item;

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;

  // Table write for update items with an id in range
  assign wr_en = accept && (req.req_type == wfgdd_pkg::REQ_UPDATE)
              && ({1'b0, req.thread_id} < wfgdd_pkg::CNT_W'(ENTRIES));
  always_comb begin
    wr_data.present     = req.present;
    wr_data.blocked     = req.blocked;
    wr_data.waiting     = req.waiting;
    wr_data.owner_valid = req.owner_valid;
    wr_data.owner       = req.owner_id;
  end

  assign rd_addr = (state == S_WALK) ? cur : scan[EW-1:0];

  wfgdd_table #(
    .NUM_ENTRIES(ENTRIES)
  ) u_table (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_addr (req.thread_id[EW-1:0]),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  wfgdd_walk_unit #(
    .NUM_ENTRIES(ENTRIES)
  ) u_walk (
    .entry   (rd_data),
    .visited (visited[cur]),
    .on_path (on_path[cur]),
    .res     (step)
  );

  assign scan_last = (scan == CW'(ENTRIES - 1));
  assign start_ok  = rd_data.present && rd_data.blocked && rd_data.waiting;
  assign marked    = on_path[scan[EW-1:0]];
  assign out_free  = !rsp_valid || !rsp_stall;

  // Result load: members while emitting, then the summary
  always_comb begin
    load      = 1'b0;
    load_item = '0;
    if (state == S_EMIT && marked && out_free) begin
      load                = 1'b1;
      load_item.member_id = wfgdd_pkg::ID_W'(scan);
      load_item.found     = 1'b1;
    end else if (state == S_SUM && out_free) begin
      load                   = 1'b1;
      load_item.found        = found;
      load_item.member_count = member_cnt;
      load_item.num_blocked  = blocked_cnt;
      load_item.last         = 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp <= load_item;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      scan        <= '0;
      cur         <= '0;
      visited     <= '0;
      on_path     <= '0;
      blocked_cnt <= '0;
      member_cnt  <= '0;
      found       <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept && req.req_type == wfgdd_pkg::REQ_DETECT) begin
            visited     <= '0;
            on_path     <= '0;
            blocked_cnt <= '0;
            member_cnt  <= '0;
            found       <= 1'b0;
            scan        <= '0;
            state       <= S_COUNT;
          end
        end
        S_COUNT: begin
          if (rd_data.present && rd_data.blocked) begin
            blocked_cnt <= blocked_cnt + wfgdd_pkg::CNT_W'(1);
          end
          if (scan_last) begin
            scan  <= '0;
            state <= S_START;
          end else begin
            scan <= scan + CW'(1);
          end
        end
        S_START: begin
          if (start_ok) begin
            cur   <= scan[EW-1:0];
            state <= S_WALK;
          end else if (scan_last) begin
            state <= S_SUM;
          end else begin
            scan <= scan + CW'(1);
          end
        end
        S_WALK: begin
          if (!visited[cur]) begin
            visited[cur] <= 1'b1;
          end
          if (step.hit) begin
            found <= 1'b1;
            scan  <= '0;
            state <= S_EMIT;
          end else if (step.stop) begin
            // failed walk drops its path marks, then tries the next start or, after the last, goes to the summary
            on_path <= '0;
            if (scan_last) begin
              state <= S_SUM;
            end else begin
              scan  <= scan + CW'(1);
              state <= S_START;
            end
          end else begin
            on_path[cur] <= 1'b1;
            cur          <= step.next_id[EW-1:0];
          end
        end
        S_EMIT: begin
          if (!marked || out_free) begin
            if (marked) begin
              member_cnt <= member_cnt + wfgdd_pkg::CNT_W'(1);
            end
            if (scan_last) begin
              state <= S_SUM;
            end else begin
              scan <= scan + CW'(1);
            end
          end
        end
        S_SUM: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/wfgdd_table.sv =====
module wfgdd_table #(
  parameter int NUM_ENTRIES = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           wr_en,
  input  logic [$clog2(NUM_ENTRIES)-1:0] wr_addr,
  input  wfgdd_pkg::entry_t              wr_data,
  input  logic [$clog2(NUM_ENTRIES)-1:0] rd_addr,
  output wfgdd_pkg::entry_t              rd_data
);

  wfgdd_pkg::entry_t entries [NUM_ENTRIES];

  // Single write port, cleared on reset
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        entries[i] <= '0;
      end
    end else if (wr_en) begin
      entries[wr_addr] <= wr_data;
    end
  end

  // Single read port
  assign rd_data = entries[rd_addr];

endmodule

// ===== hw/rtl/wfgdd_walk_unit.sv =====
module wfgdd_walk_unit #(
  parameter int NUM_ENTRIES = 16
) (
  input  wfgdd_pkg::entry_t    entry,
  input  logic                 visited,
  input  logic                 on_path,
  output wfgdd_pkg::walk_res_t res
);

  logic owner_ok;
  logic edge_ok;

  // Successor must name a stored entry
  assign owner_ok = {1'b0, entry.owner} < wfgdd_pkg::CNT_W'(NUM_ENTRIES);
  assign edge_ok  = entry.present && entry.waiting && entry.owner_valid && owner_ok;

  // A visited node ends the walk; it closes a cycle only if still on the path
  always_comb begin
    res.stop    = visited || !edge_ok;
    res.hit     = visited && on_path;
    res.next_id = entry.owner;
  end

endmodule
